@@ hw/rtl/avf_pkg.sv @@
// Viewport fit package: pixel aspect and native-size constants.
// No dependencies; referenced by avf_front, avf_scale and avf_back.
`default_nettype none
package avf_pkg;
	localparam int unsigned WIDE_NUM = 7;
	localparam int unsigned WIDE_DEN = 6;
	localparam int unsigned NATIVE_W_SHIFT = 8;
	localparam int unsigned NATIVE_H = 224;
	localparam int unsigned NATIVE_H_LO_SHIFT = 5;
endpackage
`default_nettype wire

@@ hw/rtl/avf_front.sv @@
// Viewport fit front end: cross products, ratio compare, scale fraction pick.
// Two register stages; uses avf_pkg.
`default_nettype none
module avf_front #(
	parameter int unsigned S = 12,
	parameter int unsigned T = 14
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [S-1:0] sw,
	input  wire logic [S-1:0] sh,
	input  wire logic [T-1:0] tw,
	input  wire logic [T-1:0] th,
	input  wire logic         stretch,
	input  wire logic         whole,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [T+2:0]      num,
	output logic [S+2:0]      den,
	output logic [S-1:0]      sw_o,
	output logic [S-1:0]      sh_o,
	output logic [T-1:0]      tw_o,
	output logic [T-1:0]      th_o,
	output logic              bypass_o,
	output logic              whole_o,
	output logic              sel_a_o,
	output logic              floor_o
);
	localparam int unsigned PW = S + T + 3;

	logic         v_s1, v_s2, rdy1, rdy2;
	logic [S-1:0] sw_s1, sh_s1, sw_s2, sh_s2;
	logic [T-1:0] tw_s1, th_s1, tw_s2, th_s2;
	logic         byp_s1, whole_s1, byp_s2, whole_s2, sel_s2, floor_s2;
	logic [T+2:0] tw6, tw6_s1, num_s2;
	logic [S+2:0] sw7, sw7_s1, den_s2;
	logic [PW-1:0] pa_s1, pb_s1;
	logic         sel;
	logic [T+2:0] num_c;
	logic [S+2:0] den_c;

	assign tw6 = (T+3)'(tw) * (T+3)'(avf_pkg::WIDE_DEN);
	assign sw7 = (S+3)'(sw) * (S+3)'(avf_pkg::WIDE_NUM);

	assign rdy2     = !v_s2 || out_ready;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			sw_s1    <= sw;
			sh_s1    <= sh;
			tw_s1    <= tw;
			th_s1    <= th;
			whole_s1 <= whole;
			byp_s1   <= stretch || sw == '0 || sh == '0 || tw == '0 || th == '0;
			tw6_s1   <= tw6;
			sw7_s1   <= sw7;
			pa_s1    <= PW'(tw6) * PW'(sh);
			pb_s1    <= PW'(sw7) * PW'(th);
		end
	end

	assign sel   = pa_s1 < pb_s1;
	assign num_c = sel ? tw6_s1 : (T+3)'(th_s1);
	assign den_c = sel ? sw7_s1 : (S+3)'(sh_s1);

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			sw_s2    <= sw_s1;
			sh_s2    <= sh_s1;
			tw_s2    <= tw_s1;
			th_s2    <= th_s1;
			byp_s2   <= byp_s1;
			whole_s2 <= whole_s1;
			sel_s2   <= sel;
			num_s2   <= num_c;
			den_s2   <= den_c;
			floor_s2 <= whole_s1 && ((T+S+3)'(num_c) >= (T+S+3)'(den_c));
		end
	end

	assign out_valid = v_s2;
	assign num       = num_s2;
	assign den       = den_s2;
	assign sw_o      = sw_s2;
	assign sh_o      = sh_s2;
	assign tw_o      = tw_s2;
	assign th_o      = th_s2;
	assign bypass_o  = byp_s2;
	assign whole_o   = whole_s2;
	assign sel_a_o   = sel_s2;
	assign floor_o   = floor_s2;
endmodule
`default_nettype wire

@@ hw/rtl/avf_div.sv @@
// Viewport fit divider: restoring division, one quotient bit per stage.
// Carries an opaque sideband alongside; no package dependency.
`default_nettype none
module avf_div #(
	parameter int unsigned NW = 17,
	parameter int unsigned DW = 15,
	parameter int unsigned QW = 14,
	parameter int unsigned SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [QW-1:0]      quotient,
	output logic [SW-1:0]      side_out
);
	localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

	logic [NW-1:0] rem_s  [QW];
	logic [DW-1:0] dvs_s  [QW];
	logic [QW-1:0] quo_s  [QW];
	logic [SW-1:0] side_s [QW];
	logic          vld_s  [QW];
	logic          rdy    [QW+1];

	assign rdy[QW] = out_ready;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [NW-1:0] r_i;
		logic [DW-1:0] d_i;
		logic [QW-1:0] q_i;
		logic [SW-1:0] s_i;
		logic          v_i;
		logic [CW-1:0] trial;
		logic [CW-1:0] diff;
		logic          take;

		if (k == 0) begin : g_first
			assign r_i = dividend;
			assign d_i = divisor;
			assign q_i = '0;
			assign s_i = side_in;
			assign v_i = in_valid;
		end else begin : g_next
			assign r_i = rem_s[k-1];
			assign d_i = dvs_s[k-1];
			assign q_i = quo_s[k-1];
			assign s_i = side_s[k-1];
			assign v_i = vld_s[k-1];
		end

		assign trial = CW'(d_i) << (QW - 1 - k);
		assign take  = CW'(r_i) >= trial;
		assign diff  = CW'(r_i) - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && v_i) begin
				rem_s[k]  <= take ? diff[NW-1:0] : r_i;
				dvs_s[k]  <= d_i;
				quo_s[k]  <= q_i | (QW'(take) << (QW - 1 - k));
				side_s[k] <= s_i;
			end
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[QW-1];
	assign quotient  = quo_s[QW-1];
	assign side_out  = side_s[QW-1];
endmodule
`default_nettype wire

@@ hw/rtl/avf_scale.sv @@
// Viewport fit scale stage: forms the rounded size numerator and divisor.
// One register stage; uses avf_pkg.
`default_nettype none
module avf_scale #(
	parameter int unsigned S = 12,
	parameter int unsigned T = 14
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [T-1:0] q,
	input  wire logic [S-1:0] sw,
	input  wire logic [S-1:0] sh,
	input  wire logic [T-1:0] tw,
	input  wire logic [T-1:0] th,
	input  wire logic         floor_i,
	input  wire logic         sel_a,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [S+T+3:0]    n_o,
	output logic [S+3:0]      d_o,
	output logic [T-1:0]      hq_o
);
	localparam int unsigned NW = S + T + 4;
	localparam int unsigned DW = S + 4;

	logic          v_s1;
	logic [DW-1:0] sw14, sh12, sw7, sh6, m1, c, d;
	logic [T-1:0]  m2;
	logic [S+T-1:0] hq_full;
	logic [NW-1:0] n_s1;
	logic [DW-1:0] d_s1;
	logic [T-1:0]  hq_s1;

	assign sw14 = DW'(sw) * DW'(2 * avf_pkg::WIDE_NUM);
	assign sh12 = DW'(sh) * DW'(2 * avf_pkg::WIDE_DEN);
	assign sw7  = DW'(sw) * DW'(avf_pkg::WIDE_NUM);
	assign sh6  = DW'(sh) * DW'(avf_pkg::WIDE_DEN);

	always_comb begin
		priority if (floor_i) begin
			m1 = sw14;
			m2 = q;
			c  = DW'(avf_pkg::WIDE_DEN);
			d  = DW'(2 * avf_pkg::WIDE_DEN);
		end else if (sel_a) begin
			m1 = sh12;
			m2 = tw;
			c  = sw7;
			d  = sw14;
		end else begin
			m1 = sw14;
			m2 = th;
			c  = sh6;
			d  = sh12;
		end
	end

	assign hq_full = (S+T)'(sh) * (S+T)'(q);

	assign in_ready = !v_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			n_s1  <= NW'(m1) * NW'(m2) + NW'(c);
			d_s1  <= d;
			hq_s1 <= hq_full[T-1:0];
		end
	end

	assign out_valid = v_s1;
	assign n_o       = n_s1;
	assign d_o       = d_s1;
	assign hq_o      = hq_s1;
endmodule
`default_nettype wire

@@ hw/rtl/avf_back.sv @@
// Viewport fit back end: size pick, gap snap, centring offsets, output register.
// Three register stages; uses avf_pkg.
`default_nettype none
module avf_back #(
	parameter int unsigned T = 14
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [T-1:0] res,
	input  wire logic [T-1:0] hq,
	input  wire logic [T-1:0] tw,
	input  wire logic [T-1:0] th,
	input  wire logic         bypass,
	input  wire logic         whole,
	input  wire logic         sel_a,
	input  wire logic         floor_i,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [T-1:0]      view_x,
	output logic [T-1:0]      view_y,
	output logic [T-1:0]      view_width,
	output logic [T-1:0]      view_height
);
	localparam int unsigned GW = T + avf_pkg::NATIVE_W_SHIFT;

	logic         v_s1, v_s2, v_s3, rdy1, rdy2, rdy3;
	logic [T-1:0] w_c, h_c;
	logic [T-1:0] w_s1, h_s1, tw_s1, th_s1;
	logic         nosnap_s1;
	logic [T-1:0] gw1, gh1;
	logic [GW-1:0] limw, limh;
	logic         snap_w, snap_h;
	logic [T-1:0] w_s2, h_s2, tw_s2, th_s2;
	logic [T-1:0] x_s3, y_s3, w_s3, h_s3;
	logic [T-1:0] w_pick, h_pick;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_comb begin
		priority if (bypass) begin
			w_pick = tw;
			h_pick = th;
		end else if (floor_i) begin
			w_pick = res;
			h_pick = hq;
		end else if (sel_a) begin
			w_pick = tw;
			h_pick = res;
		end else begin
			w_pick = res;
			h_pick = th;
		end
		w_c = (w_pick == '0) ? T'(1) : w_pick;
		h_c = (h_pick == '0) ? T'(1) : h_pick;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			w_s1      <= w_c;
			h_s1      <= h_c;
			tw_s1     <= tw;
			th_s1     <= th;
			nosnap_s1 <= whole || bypass;
		end
	end

	assign gw1  = tw_s1 - w_s1 - T'(1);
	assign gh1  = th_s1 - h_s1 - T'(1);
	assign limw = GW'(gw1) << avf_pkg::NATIVE_W_SHIFT;
	assign limh = (GW'(gh1) << avf_pkg::NATIVE_W_SHIFT)
		- (GW'(gh1) << avf_pkg::NATIVE_H_LO_SHIFT);
	assign snap_w = !nosnap_s1 && (w_s1 < tw_s1) && (limw < GW'(tw_s1));
	assign snap_h = !nosnap_s1 && (h_s1 < th_s1) && (limh < GW'(th_s1));

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			w_s2  <= snap_w ? tw_s1 : w_s1;
			h_s2  <= snap_h ? th_s1 : h_s1;
			tw_s2 <= tw_s1;
			th_s2 <= th_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			x_s3 <= (w_s2 <= tw_s2) ? (tw_s2 - w_s2) >> 1 : '0;
			y_s3 <= (h_s2 <= th_s2) ? (th_s2 - h_s2) >> 1 : '0;
			w_s3 <= w_s2;
			h_s3 <= h_s2;
		end
	end

	assign out_valid   = v_s3;
	assign view_x      = x_s3;
	assign view_y      = y_s3;
	assign view_width  = w_s3;
	assign view_height = h_s3;
endmodule
`default_nettype wire

@@ hw/rtl/aspect_viewport_fit_core.sv @@
// Viewport fit top level: letterboxed viewport for a 7:6 pixel-aspect source.
// Depends on avf_pkg, avf_front, avf_div, avf_scale, avf_back.
//
//   channel  | handshake            | payload
//   request  | in_valid / in_ready  | src_width/height, target_width/height, modes
//   result   | out_valid/ out_ready | view_x, view_y, view_width, view_height
//
// Takes one request per cycle while no stage is stalled by the result side.
// Depth is set by the two restoring dividers, one quotient bit per stage each.
// Reset clears all stage valid bits; payload registers are not reset.
// Each stage holds its request only while the next one is full and stalled,
// so bubbles close up and requests are taken while a result waits.
`default_nettype none
module aspect_viewport_fit_core #(
	parameter int unsigned SOURCE_DIM_BITS = 12,
	parameter int unsigned TARGET_DIM_BITS = 14
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [SOURCE_DIM_BITS-1:0] src_width,
	input  wire logic [SOURCE_DIM_BITS-1:0] src_height,
	input  wire logic [TARGET_DIM_BITS-1:0] target_width,
	input  wire logic [TARGET_DIM_BITS-1:0] target_height,
	input  wire logic                       stretch_mode,
	input  wire logic                       whole_scale_mode,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [TARGET_DIM_BITS-1:0]      view_x,
	output logic [TARGET_DIM_BITS-1:0]      view_y,
	output logic [TARGET_DIM_BITS-1:0]      view_width,
	output logic [TARGET_DIM_BITS-1:0]      view_height
);
	localparam int unsigned S   = SOURCE_DIM_BITS;
	localparam int unsigned T   = TARGET_DIM_BITS;
	localparam int unsigned SW1 = 2 * S + 2 * T + 4;
	localparam int unsigned SW2 = 2 * T + 4;

	logic         f_valid, f_ready;
	logic [T+2:0] f_num;
	logic [S+2:0] f_den;
	logic [S-1:0] f_sw, f_sh;
	logic [T-1:0] f_tw, f_th;
	logic         f_byp, f_whole, f_sel, f_floor;

	logic           d1_valid, d1_ready;
	logic [T-1:0]   d1_q;
	logic [SW1-1:0] d1_side;
	logic [S-1:0]   d1_sw, d1_sh;
	logic [T-1:0]   d1_tw, d1_th;
	logic           d1_byp, d1_whole, d1_sel, d1_floor;

	logic           sc_valid, sc_ready;
	logic [S+T+3:0] sc_n;
	logic [S+3:0]   sc_d;
	logic [T-1:0]   sc_hq;

	logic             d2_valid, d2_ready;
	logic [T-1:0]     d2_q;
	logic [T+SW2-1:0] d2_side;
	logic [T-1:0]     d2_hq, d2_tw, d2_th;
	logic             d2_byp, d2_whole, d2_sel, d2_floor;

	avf_front #(.S(S), .T(T)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sw        (src_width),
		.sh        (src_height),
		.tw        (target_width),
		.th        (target_height),
		.stretch   (stretch_mode),
		.whole     (whole_scale_mode),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.num       (f_num),
		.den       (f_den),
		.sw_o      (f_sw),
		.sh_o      (f_sh),
		.tw_o      (f_tw),
		.th_o      (f_th),
		.bypass_o  (f_byp),
		.whole_o   (f_whole),
		.sel_a_o   (f_sel),
		.floor_o   (f_floor)
	);

	avf_div #(.NW(T + 3), .DW(S + 3), .QW(T), .SW(SW1)) u_div_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.dividend  (f_num),
		.divisor   (f_den),
		.side_in   ({f_sw, f_sh, f_tw, f_th, f_byp, f_whole, f_sel, f_floor}),
		.out_valid (d1_valid),
		.out_ready (d1_ready),
		.quotient  (d1_q),
		.side_out  (d1_side)
	);

	assign {d1_sw, d1_sh, d1_tw, d1_th, d1_byp, d1_whole, d1_sel, d1_floor} = d1_side;

	avf_scale #(.S(S), .T(T)) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d1_valid),
		.in_ready  (d1_ready),
		.q         (d1_q),
		.sw        (d1_sw),
		.sh        (d1_sh),
		.tw        (d1_tw),
		.th        (d1_th),
		.floor_i   (d1_floor),
		.sel_a     (d1_sel),
		.out_valid (sc_valid),
		.out_ready (sc_ready),
		.n_o       (sc_n),
		.d_o       (sc_d),
		.hq_o      (sc_hq)
	);

	// sideband rides one stage behind the scale stage's inputs
	logic [SW2-1:0] sc_side_q;

	always_ff @(posedge clk) begin
		if (d1_ready && d1_valid) begin
			sc_side_q <= {d1_tw, d1_th, d1_byp, d1_whole, d1_sel, d1_floor};
		end
	end

	avf_div #(.NW(S + T + 4), .DW(S + 4), .QW(T), .SW(T + SW2)) u_div_size (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sc_valid),
		.in_ready  (sc_ready),
		.dividend  (sc_n),
		.divisor   (sc_d),
		.side_in   ({sc_side_q, sc_hq}),
		.out_valid (d2_valid),
		.out_ready (d2_ready),
		.quotient  (d2_q),
		.side_out  (d2_side)
	);

	assign {d2_tw, d2_th, d2_byp, d2_whole, d2_sel, d2_floor, d2_hq} = d2_side;

	avf_back #(.T(T)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (d2_valid),
		.in_ready    (d2_ready),
		.res         (d2_q),
		.hq          (d2_hq),
		.tw          (d2_tw),
		.th          (d2_th),
		.bypass      (d2_byp),
		.whole       (d2_whole),
		.sel_a       (d2_sel),
		.floor_i     (d2_floor),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.view_x      (view_x),
		.view_y      (view_y),
		.view_width  (view_width),
		.view_height (view_height)
	);
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking bench for aspect_viewport_fit_core: directed and random size requests.
// Predicts each viewport in exact integer arithmetic; depends on the core only.
`default_nettype none
module testbench;
	localparam int SW_BITS = 12;
	localparam int TW_BITS = 14;
	localparam int LATENCY = 2 * TW_BITS + 6;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [SW_BITS-1:0] src_w;
		logic [SW_BITS-1:0] src_h;
		logic [TW_BITS-1:0] tgt_w;
		logic [TW_BITS-1:0] tgt_h;
		logic stretch;
		logic whole;
	} fit_req_t;

	typedef struct packed {
		logic [TW_BITS-1:0] x;
		logic [TW_BITS-1:0] y;
		logic [TW_BITS-1:0] w;
		logic [TW_BITS-1:0] h;
	} viewport_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [SW_BITS-1:0] src_width = '0;
	logic [SW_BITS-1:0] src_height = '0;
	logic [TW_BITS-1:0] target_width = '0;
	logic [TW_BITS-1:0] target_height = '0;
	logic stretch_mode = 0;
	logic whole_scale_mode = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [TW_BITS-1:0] view_x, view_y, view_width, view_height;

	fit_req_t pending_reqs[$];
	viewport_t expected_views[$];
	int mismatches = 0;
	int cycle_count = 0;
	int hold_off = 0;
	bit calm = 0;
	bit pause_send = 0;

	aspect_viewport_fit_core #(.SOURCE_DIM_BITS(SW_BITS), .TARGET_DIM_BITS(TW_BITS)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.src_width(src_width), .src_height(src_height),
		.target_width(target_width), .target_height(target_height),
		.stretch_mode(stretch_mode), .whole_scale_mode(whole_scale_mode),
		.out_valid(out_valid), .out_ready(out_ready),
		.view_x(view_x), .view_y(view_y), .view_width(view_width), .view_height(view_height)
	);

	function automatic longint unsigned snap_to_target(longint unsigned size,
			longint unsigned tgt, longint unsigned native);
		if (size < tgt && (tgt - size) <= native)
			return tgt;
		return size;
	endfunction

	function automatic viewport_t fit_viewport(fit_req_t r);
		longint unsigned sw, sh, tw, th, num, den, w, h;
		viewport_t v;
		sw = r.src_w;
		sh = r.src_h;
		tw = r.tgt_w;
		th = r.tgt_h;
		if (r.stretch || sw == 0 || sh == 0 || tw == 0 || th == 0) begin
			v.x = '0;
			v.y = '0;
			v.w = (tw != 0) ? tw[TW_BITS-1:0] : TW_BITS'(1);
			v.h = (th != 0) ? th[TW_BITS-1:0] : TW_BITS'(1);
			return v;
		end
		if (6 * tw * sh < 7 * sw * th) begin
			num = 6 * tw;
			den = 7 * sw;
		end else begin
			num = th;
			den = sh;
		end
		if (r.whole && num >= den) begin
			num = num / den;
			den = 1;
		end
		w = (14 * sw * num + 6 * den) / (12 * den);
		h = (2 * sh * num + den) / (2 * den);
		if (w == 0) w = 1;
		if (h == 0) h = 1;
		if (!r.whole) begin
			w = snap_to_target(w, tw, (tw + 255) / 256);
			h = snap_to_target(h, th, (th + 223) / 224);
		end
		v.x = (w <= tw) ? TW_BITS'((tw - w) / 2) : '0;
		v.y = (h <= th) ? TW_BITS'((th - h) / 2) : '0;
		v.w = w[TW_BITS-1:0];
		v.h = h[TW_BITS-1:0];
		return v;
	endfunction

	task automatic report_mismatch(string msg);
		$display("view mismatch: %s", msg);
		mismatches++;
	endtask

	function automatic fit_req_t random_req();
		fit_req_t r;
		int pick;
		pick = $urandom_range(0, 9);
		r.src_w = (pick < 6) ? SW_BITS'($urandom_range(1, 640)) : SW_BITS'($urandom);
		r.src_h = (pick < 6) ? SW_BITS'($urandom_range(1, 480)) : SW_BITS'($urandom);
		r.tgt_w = (pick < 7) ? TW_BITS'($urandom_range(1, 4000)) : TW_BITS'($urandom);
		r.tgt_h = (pick < 7) ? TW_BITS'($urandom_range(1, 3000)) : TW_BITS'($urandom);
		if ($urandom_range(0, 19) == 0) r.src_w = '0;
		if ($urandom_range(0, 19) == 0) r.tgt_h = '0;
		r.stretch = ($urandom_range(0, 7) == 0);
		r.whole = 1'($urandom);
		return r;
	endfunction

	function automatic fit_req_t make_req(int sw, int sh, int tw, int th, bit st, bit wh);
		fit_req_t r;
		r.src_w = SW_BITS'(sw); r.src_h = SW_BITS'(sh);
		r.tgt_w = TW_BITS'(tw); r.tgt_h = TW_BITS'(th);
		r.stretch = st; r.whole = wh;
		return r;
	endfunction

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_views.push_back(fit_viewport({src_width, src_height,
					target_width, target_height, stretch_mode, whole_scale_mode}));
				void'(pending_reqs.pop_front());
			end
			if (pending_reqs.size() > 0 && !pause_send &&
					(calm || $urandom_range(0, 99) >= 25 ||
					(in_valid && !in_ready))) begin
				in_valid <= 1;
				{src_width, src_height, target_width, target_height,
					stretch_mode, whole_scale_mode} <= pending_reqs[0];
			end else if (!(in_valid && !in_ready)) begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		viewport_t want;
		cycle_count++;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_views.size() == 0) begin
					report_mismatch("view result with nothing expected");
				end else begin
					want = expected_views.pop_front();
					if (view_x !== want.x)
						report_mismatch($sformatf("view_x got %0d expected %0d",
							view_x, want.x));
					if (view_y !== want.y)
						report_mismatch($sformatf("view_y got %0d expected %0d",
							view_y, want.y));
					if (view_width !== want.w)
						report_mismatch($sformatf("view_width got %0d expected %0d",
							view_width, want.w));
					if (view_height !== want.h)
						report_mismatch($sformatf("view_height got %0d expected %0d",
							view_height, want.h));
				end
			end
			if (hold_off > 0) begin
				hold_off--;
				out_ready <= 0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 25);
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		pending_reqs.push_back(make_req(256, 224, 1920, 1080, 0, 0));
		pending_reqs.push_back(make_req(256, 224, 1920, 1080, 0, 1));
		pending_reqs.push_back(make_req(256, 224, 1920, 1080, 1, 0));
		pending_reqs.push_back(make_req(0, 224, 1920, 1080, 0, 0));
		pending_reqs.push_back(make_req(256, 0, 1920, 1080, 0, 1));
		pending_reqs.push_back(make_req(256, 224, 0, 1080, 0, 0));
		pending_reqs.push_back(make_req(256, 224, 1920, 0, 0, 0));
		pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0));
		pending_reqs.push_back(make_req(0, 0, 0, 0, 1, 1));
		pending_reqs.push_back(make_req(4095, 4095, 16383, 16383, 0, 0));
		pending_reqs.push_back(make_req(4095, 4095, 16383, 16383, 0, 1));
		pending_reqs.push_back(make_req(1, 1, 16383, 16383, 0, 1));
		pending_reqs.push_back(make_req(1, 1, 16383, 16383, 0, 0));
		pending_reqs.push_back(make_req(4095, 4095, 1, 1, 0, 0));
		pending_reqs.push_back(make_req(4095, 1, 1, 16383, 0, 1));
		pending_reqs.push_back(make_req(1, 4095, 16383, 1, 0, 0));
		pending_reqs.push_back(make_req(6, 7, 49, 49, 0, 0));
		pending_reqs.push_back(make_req(6, 7, 49, 49, 0, 1));
		pending_reqs.push_back(make_req(256, 224, 598, 448, 0, 1));
		pending_reqs.push_back(make_req(256, 224, 600, 450, 0, 0));
		pending_reqs.push_back(make_req(256, 224, 300, 224, 0, 1));
		pending_reqs.push_back(make_req(2730, 2730, 16383, 16383, 1, 0));
		wait (arst_n);
		// fast stretch with no idling, then a long output stall
		calm = 1;
		for (int i = 0; i < 300; i++) pending_reqs.push_back(random_req());
		wait (pending_reqs.size() < 250);
		calm = 0;
		hold_off = 3 * LATENCY + 40;
		wait (pending_reqs.size() == 0);
		// hold input until every result has drained
		pause_send = 1;
		wait (expected_views.size() == 0 && !in_valid);
		pause_send = 0;
		for (int i = 0; i < 1230; i++) pending_reqs.push_back(random_req());
		wait (pending_reqs.size() == 0 && !in_valid);
		wait (expected_views.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
`default_nettype wire
